[hdl/k_weighted_loudness_meter_top_defines.svh]
// Assertion macros for the loudness meter.
`ifndef K_WEIGHTED_LOUDNESS_METER_TOP_DEFINES_SVH
`define K_WEIGHTED_LOUDNESS_METER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define KWL_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define KWL_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define KWL_ASSERT_IMP(label, clk, rst_n, a, b)
`define KWL_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

[hdl/kwl_pkg.sv]
package kwl_pkg;
    localparam int WINDOW_BLOCKS_DEF = 30;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_W = 32;
    localparam int POW_W = 40;
    localparam int LEN_W = 16;
    localparam int CNT_W = 24;
    localparam int NUM_REGS = 8;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_SHELF_B0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_SHELF_B1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_SHELF_B2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_SHELF_A1 = 3'd3;
    localparam logic [IDX_W-1:0] REG_SHELF_A2 = 3'd4;
    localparam logic [IDX_W-1:0] REG_HP_A1 = 3'd5;
    localparam logic [IDX_W-1:0] REG_HP_A2 = 3'd6;
    localparam logic [IDX_W-1:0] REG_BLOCK_LEN = 3'd7;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MAC,
        OP_FINISH,
        OP_SQUARE,
        OP_ENERGY,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_TAKE,
        OP_WIN_UPDATE,
        OP_RESULT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] sel;
        logic       chan;
    } cmd_t;

    typedef struct packed {
        logic block_end;
        logic div_done;
    } status_t;
endpackage

[hdl/kwl_ram.sv]
module kwl_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 30,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hdl/kwl_ctrl.sv]
module kwl_ctrl import kwl_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);
    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_MAC    = 11'b00000000010,
        S_FIN    = 11'b00000000100,
        S_SQ     = 11'b00000001000,
        S_EN     = 11'b00000010000,
        S_DINIT  = 11'b00000100000,
        S_DSTEP  = 11'b00001000000,
        S_DTAKE  = 11'b00010000000,
        S_WIN    = 11'b00100000000,
        S_RES    = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] sel_reg, sel_next;
    logic       chan_reg, chan_next;
    logic       out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= '0;
            chan_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            chan_reg  <= chan_next;
        end
    end

    assign out_busy  = (state_reg == S_OUT);
    assign out_valid = out_busy;
    assign in_stall  = (state_reg != S_IDLE);

    // Multiply slots per channel: five shelf terms then two high-pass terms.
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        chan_next  = chan_reg;
        cmd.op     = OP_NONE;
        cmd.sel    = sel_reg;
        cmd.chan   = chan_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_MAC;
                    sel_next   = '0;
                    chan_next  = 1'b0;
                end
            end
            S_MAC:
            begin
                cmd.op = OP_MAC;
                if (sel_reg == 5'd4 || sel_reg == 5'd6)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    sel_next = sel_reg + 5'd1;
                end
            end
            S_FIN:
            begin
                cmd.op = OP_FINISH;
                if (sel_reg == 5'd4)
                begin
                    sel_next   = 5'd5;
                    state_next = S_MAC;
                end
                else if (!chan_reg)
                begin
                    chan_next  = 1'b1;
                    sel_next   = '0;
                    state_next = S_MAC;
                end
                else
                begin
                    state_next = S_SQ;
                    chan_next  = 1'b0;
                end
            end
            S_SQ:
            begin
                cmd.op = OP_SQUARE;
                if (chan_reg)
                begin
                    state_next = S_EN;
                end
                chan_next = ~chan_reg;
            end
            S_EN:
            begin
                cmd.op = OP_ENERGY;
                if (status.block_end)
                begin
                    state_next = S_DINIT;
                    chan_next  = 1'b0;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DINIT:
            begin
                cmd.op     = OP_DIV_INIT;
                state_next = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.op = OP_DIV_STEP;
                if (status.div_done)
                begin
                    state_next = S_DTAKE;
                end
            end
            S_DTAKE:
            begin
                cmd.op = OP_DIV_TAKE;
                unique case (sel_reg)
                    5'd0:    begin sel_next = 5'd1; state_next = S_DINIT; end
                    5'd1:    begin sel_next = 5'd2; state_next = S_WIN; end
                    5'd2:    begin sel_next = 5'd3; state_next = S_DINIT; end
                    default: state_next = S_OUT;
                endcase
            end
            S_WIN:
            begin
                cmd.op     = OP_WIN_UPDATE;
                state_next = S_RES;
            end
            S_RES:
            begin
                cmd.op     = OP_RESULT;
                state_next = S_DINIT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_EN && status.block_end)
        begin
            sel_next = '0;
        end
    end
endmodule

[hdl/kwl_dp.sv]
module kwl_dp import kwl_pkg::*; #(
    parameter int WINDOW_BLOCKS = WINDOW_BLOCKS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    output status_t                       status,
    input  logic signed [SAMPLE_BITS-1:0] left_sample,
    input  logic signed [SAMPLE_BITS-1:0] right_sample,
    input  logic signed [COEF_W-1:0]      coef [7],
    input  logic [LEN_W-1:0]              block_length,
    output logic                          block_done,
    output logic [POW_W-1:0]              block_mean_power,
    output logic [POW_W-1:0]              short_term_power,
    output logic                          short_term_valid,
    output logic [POW_W-1:0]              integrated_power,
    output logic                          integrated_valid
);
    localparam int WA_W = (WINDOW_BLOCKS > 1) ? $clog2(WINDOW_BLOCKS) : 1;
    localparam int FILL_W = $clog2(WINDOW_BLOCKS + 1);
    localparam int WT_W = POW_W + FILL_W;
    localparam int FRAC = 2 * (SAMPLE_BITS - 1);
    localparam int SHR = (FRAC >= 32) ? (FRAC - 32) : 0;
    localparam int SHL = (FRAC < 32) ? (32 - FRAC) : 0;
    localparam logic [WA_W-1:0] WLAST = WA_W'(WINDOW_BLOCKS - 1);
    localparam logic [FILL_W-1:0] WFULL = FILL_W'(WINDOW_BLOCKS);
    localparam int ACC_W = 72;

    // Filter state per channel: shelf x1,x2,y1,y2, high-pass x1,x2,y1,y2.
    logic signed [31:0] mem_reg [2][8];
    logic signed [31:0] x_reg [2];
    logic signed [31:0] y1_reg;
    logic signed [31:0] yout_reg [2];
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic prod_v_reg;
    logic [63:0] sq_reg;
    logic [63:0] esum_reg [2];
    logic [LEN_W-1:0] cnt_reg;
    logic [WA_W-1:0] widx_reg;
    logic [FILL_W-1:0] wfill_reg;
    logic [WT_W-1:0] wtot_reg;
    logic [63:0] otot_reg;
    logic [CNT_W-1:0] ocnt_reg;
    logic [63:0] q_reg, rem_reg, num_reg;
    logic [63:0] den_reg;
    logic [6:0] dcnt_reg;
    logic [POW_W-1:0] lp_reg;
    logic [POW_W-1:0] bp_reg;
    logic [POW_W-1:0] st_reg;
    logic [POW_W-1:0] ip_reg;
    logic [POW_W-1:0] old_rd;
    logic done_reg;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] cnt_inc;
    logic               ch;
    logic signed [31:0] mul_a, mul_b;
    logic               mul_neg;
    logic signed [ACC_W-1:0] fin_sum, fin_r;
    logic signed [31:0] fin_sat;
    logic [64:0] e_add;
    logic [31:0] mag;
    logic [64:0] rsub;
    logic [POW_W-1:0] q32;
    logic [POW_W:0] bp_sum;
    logic [WT_W-1:0] wt_new;
    logic [64:0] ot_add;

    assign ch = cmd.chan;
    assign len = (block_length == '0) ? LEN_W'(1) : block_length;
    assign cnt_inc = cnt_reg + LEN_W'(1);

    // One 32x32 product per cycle while the controller issues MAC commands, registered before accumulation.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        mul_neg = 1'b0;
        unique case (cmd.sel)
            5'd0: begin mul_a = coef[0]; mul_b = x_reg[ch]; end
            5'd1: begin mul_a = coef[1]; mul_b = mem_reg[ch][0]; end
            5'd2: begin mul_a = coef[2]; mul_b = mem_reg[ch][1]; end
            5'd3: begin mul_a = coef[3]; mul_b = mem_reg[ch][2]; mul_neg = 1'b1; end
            5'd4: begin mul_a = coef[4]; mul_b = mem_reg[ch][3]; mul_neg = 1'b1; end
            5'd5: begin mul_a = coef[5]; mul_b = mem_reg[ch][6]; mul_neg = 1'b1; end
            5'd6: begin mul_a = coef[6]; mul_b = mem_reg[ch][7]; mul_neg = 1'b1; end
            default: ;
        endcase
    end

    assign fin_sum = acc_reg + (prod_v_reg ? ACC_W'(prod_reg) : '0);
    assign fin_r = (fin_sum + ACC_W'(64'sd134217728)) >>> 28;
    assign fin_sat = (fin_r > ACC_W'(64'sd2147483647)) ? 32'sh7fffffff :
                     (fin_r < -ACC_W'(64'sd2147483648)) ? 32'sh80000000 : fin_r[31:0];
    assign mag = yout_reg[ch][31] ? 32'(-yout_reg[ch]) : yout_reg[ch];
    // The square registered last cycle belongs to the other channel.
    assign e_add = {1'b0, esum_reg[~ch]} + {1'b0, sq_reg};
    assign rsub = {rem_reg[62:0], num_reg[63]} - {1'b0, den_reg};

    always_comb
    begin
        if (FRAC >= 32)
        begin
            q32 = ((q_reg >> SHR) > 64'hFF_FFFF_FFFF) ? '1 : POW_W'(q_reg >> SHR);
        end
        else
        begin
            q32 = (q_reg > (64'hFF_FFFF_FFFF >> SHL)) ? '1 : POW_W'(q_reg << SHL);
        end
    end

    assign bp_sum = {1'b0, lp_reg} + {1'b0, q32};
    assign wt_new = wtot_reg - ((wfill_reg >= WFULL) ? WT_W'(old_rd) : '0)
                    + WT_W'(bp_reg);
    assign ot_add = {1'b0, otot_reg} + {25'd0, bp_reg};

    kwl_ram #(.WIDTH(POW_W), .DEPTH(WINDOW_BLOCKS)) u_win (
        .clk   (clk),
        .we    (cmd.op == OP_WIN_UPDATE),
        .waddr (widx_reg),
        .wdata (bp_reg),
        .raddr (widx_reg),
        .rdata (old_rd)
    );

    assign status.block_end = (cnt_inc == '0) || (cnt_inc >= len);
    assign status.div_done = (dcnt_reg == 7'd64);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 2; c++)
            begin
                for (int k = 0; k < 8; k++)
                begin
                    mem_reg[c][k] <= '0;
                end
                esum_reg[c] <= '0;
            end
            cnt_reg   <= '0;
            widx_reg  <= '0;
            wfill_reg <= '0;
            wtot_reg  <= '0;
            otot_reg  <= '0;
            ocnt_reg  <= '0;
            st_reg    <= '0;
            ip_reg    <= '0;
            prod_v_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                OP_LOAD:
                begin
                    x_reg[0]   <= 32'(left_sample);
                    x_reg[1]   <= 32'(right_sample);
                    acc_reg    <= '0;
                    prod_v_reg <= 1'b0;
                    done_reg   <= 1'b0;
                end
                OP_MAC:
                begin
                    prod_reg   <= mul_neg ? -(mul_a * mul_b) : mul_a * mul_b;
                    prod_v_reg <= 1'b1;
                    if (cmd.sel == 5'd5)
                    begin
                        acc_reg <= (ACC_W'(y1_reg) - (ACC_W'(mem_reg[ch][4]) <<< 1)
                                    + ACC_W'(mem_reg[ch][5])) <<< 28;
                    end
                    else
                    begin
                        acc_reg <= fin_sum;
                    end
                end
                OP_FINISH:
                begin
                    prod_v_reg <= 1'b0;
                    acc_reg    <= '0;
                    if (cmd.sel == 5'd4)
                    begin
                        y1_reg <= fin_sat;
                        mem_reg[ch][1] <= mem_reg[ch][0];
                        mem_reg[ch][0] <= x_reg[ch];
                        mem_reg[ch][3] <= mem_reg[ch][2];
                        mem_reg[ch][2] <= fin_sat;
                    end
                    else
                    begin
                        yout_reg[ch] <= fin_sat;
                        mem_reg[ch][5] <= mem_reg[ch][4];
                        mem_reg[ch][4] <= y1_reg;
                        mem_reg[ch][7] <= mem_reg[ch][6];
                        mem_reg[ch][6] <= fin_sat;
                    end
                end
                OP_SQUARE:
                begin
                    sq_reg <= mag * mag;
                    if (ch)
                    begin
                        esum_reg[0] <= e_add[64] ? '1 : e_add[63:0];
                    end
                end
                OP_ENERGY:
                begin
                    esum_reg[1] <= e_add[64] ? '1 : e_add[63:0];
                    cnt_reg <= cnt_inc;
                end
                OP_DIV_INIT:
                begin
                    rem_reg  <= '0;
                    dcnt_reg <= '0;
                    q_reg    <= '0;
                    unique case (cmd.sel)
                        5'd0:    begin num_reg <= esum_reg[0]; den_reg <= 64'(len); end
                        5'd1:    begin num_reg <= esum_reg[1]; den_reg <= 64'(len); end
                        5'd2:    begin num_reg <= 64'(wtot_reg); den_reg <= 64'(wfill_reg); end
                        default: begin num_reg <= otot_reg; den_reg <= 64'(ocnt_reg); end
                    endcase
                end
                OP_DIV_STEP:
                begin
                    if (dcnt_reg != 7'd64)
                    begin
                        num_reg  <= num_reg << 1;
                        dcnt_reg <= dcnt_reg + 7'd1;
                        if (!rsub[64])
                        begin
                            rem_reg <= rsub[63:0];
                            q_reg   <= {q_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[62:0], num_reg[63]};
                            q_reg   <= {q_reg[62:0], 1'b0};
                        end
                    end
                end
                OP_DIV_TAKE:
                begin
                    unique case (cmd.sel)
                        5'd0:    lp_reg <= q32;
                        5'd1:    bp_reg <= bp_sum[POW_W] ? '1 : bp_sum[POW_W-1:0];
                        5'd2:    st_reg <= q_reg[POW_W-1:0];
                        default:
                        begin
                            ip_reg <= (ocnt_reg == '0) ? '0 : q_reg[POW_W-1:0];
                            done_reg <= 1'b1;
                        end
                    endcase
                end
                OP_WIN_UPDATE:
                begin
                    wtot_reg <= wt_new;
                    if (wfill_reg < WFULL)
                    begin
                        wfill_reg <= wfill_reg + FILL_W'(1);
                    end
                    widx_reg <= (widx_reg == WLAST) ? '0 : widx_reg + WA_W'(1);
                    if (ocnt_reg != '1 && !ot_add[64])
                    begin
                        otot_reg <= ot_add[63:0];
                        ocnt_reg <= ocnt_reg + CNT_W'(1);
                    end
                end
                OP_RESULT:
                begin
                    cnt_reg     <= '0;
                    esum_reg[0] <= '0;
                    esum_reg[1] <= '0;
                end
                default: ;
            endcase
        end
    end

    assign block_done       = done_reg;
    assign block_mean_power = done_reg ? bp_reg : '0;
    assign short_term_power = done_reg ? st_reg : '0;
    assign short_term_valid = done_reg;
    assign integrated_power = done_reg ? ip_reg : '0;
    assign integrated_valid = done_reg && (ocnt_reg != '0);
endmodule

[hdl/k_weighted_loudness_meter_top.sv]
// K-weighted loudness meter.
// Input channel: in_valid/in_stall carry one stereo pair (left_sample,
// right_sample) per transfer. Output channel: out_valid/out_stall carry
// exactly one result per input pair; the power fields read zero unless
// block_done is set. Coefficients and block_length are written through
// cfg_valid/cfg_ready with cfg_index/cfg_data; the user must write them
// only while the meter is idle, which the block itself does not enforce.
// Each pair is filtered by one shared 32x32 multiplier, 7 products per
// channel. A block end adds four 64-step restoring divisions plus a
// window update and a result step before the result transfer.
// One pair is processed at a time; the next is taken after the result
// transfers. While the receiver stalls, the result holds and no new pair
// is taken.
// Reset clears the filter memories, energy sums, window and integrated
// statistics and restores the 48 kHz coefficient set.
`include "k_weighted_loudness_meter_top_defines.svh"
module k_weighted_loudness_meter_top import kwl_pkg::*; #(
    parameter int WINDOW_BLOCKS = WINDOW_BLOCKS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] left_sample,
    input  logic signed [SAMPLE_BITS-1:0] right_sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          block_done,
    output logic [POW_W-1:0]              block_mean_power,
    output logic [POW_W-1:0]              short_term_power,
    output logic                          short_term_valid,
    output logic [POW_W-1:0]              integrated_power,
    output logic                          integrated_valid,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [IDX_W-1:0]              cfg_index,
    input  logic [COEF_W-1:0]             cfg_data
);
    logic signed [COEF_W-1:0] coef_reg [7];
    logic [LEN_W-1:0]         len_reg;
    cmd_t                     cmd;
    status_t                  status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[0] <= 32'sd412081942;
            coef_reg[1] <= -32'sd722546695;
            coef_reg[2] <= 32'sd321691121;
            coef_reg[3] <= -32'sd453832899;
            coef_reg[4] <= 32'sd196623811;
            coef_reg[5] <= -32'sd534199295;
            coef_reg[6] <= 32'sd265770496;
            len_reg     <= 16'd4800;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_BLOCK_LEN)
            begin
                len_reg <= cfg_data[LEN_W-1:0];
            end
            else
            begin
                coef_reg[cfg_index] <= cfg_data;
            end
        end
    end

    kwl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    kwl_dp #(.WINDOW_BLOCKS(WINDOW_BLOCKS), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .left_sample      (left_sample),
        .right_sample     (right_sample),
        .coef             (coef_reg),
        .block_length     (len_reg),
        .block_done       (block_done),
        .block_mean_power (block_mean_power),
        .short_term_power (short_term_power),
        .short_term_valid (short_term_valid),
        .integrated_power (integrated_power),
        .integrated_valid (integrated_valid)
    );

    `KWL_ASSERT_IMP(a_no_take_busy, clk, rst_n, out_valid, in_stall)
    `KWL_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && out_stall, out_valid)
    `KWL_ASSERT_IMP(a_valid_flags, clk, rst_n, integrated_valid, block_done)
endmodule
